// ===== rtl/isp_frame_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// Frame deframer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ISP_FRAME_DEFRAMER_MACROS_SVH
`define ISP_FRAME_DEFRAMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IFD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ifd_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame deframer package
// Phase and event codes, framing bytes and offsets shared by the deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ifd_pkg;

  // Framing bytes.
  localparam logic [7:0] HDR_FIRST  = 8'h46;
  localparam logic [7:0] HDR_SECOND = 8'hB9;
  localparam logic [7:0] HDR_THIRD  = 8'h68;
  localparam logic [7:0] HDR_FOURTH = 8'h00;
  localparam logic [7:0] TAIL_BYTE  = 8'h16;

  // The length byte counts six bytes beyond the payload.
  localparam logic [7:0] LEN_OFFSET = 8'd6;

  // Receive phases.
  typedef enum logic [3:0] {
    PH_HUNT  = 4'd0,
    PH_H1    = 4'd1,
    PH_H2    = 4'd2,
    PH_H3    = 4'd3,
    PH_LEN   = 4'd4,
    PH_DATA  = 4'd5,
    PH_SUMHI = 4'd6,
    PH_SUMLO = 4'd7,
    PH_TAIL  = 4'd8
  } phase_t;

  // Events reported with each result transaction.
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_DATA   = 3'd1,
    EV_GOOD   = 3'd2,
    EV_SUMHI  = 3'd3,
    EV_SUMLO  = 3'd4,
    EV_TAIL   = 3'd5,
    EV_HEADER = 3'd6,
    EV_LENGTH = 3'd7
  } event_t;

endpackage

// ===== rtl/ifd_in_if.sv =====
// ----------------------------------------------------------------------------
// Deframer input channel
// Valid/ready channel carrying one received byte per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ifd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/ifd_out_if.sv =====
// ----------------------------------------------------------------------------
// Deframer output channel
// Valid/ready channel carrying one frame event per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ifd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] frame_event;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [7:0] frame_length;

  modport source (
    output valid, output frame_event, output payload_byte,
    output payload_index, output frame_length, input ready
  );
  modport sink (
    input valid, input frame_event, input payload_byte,
    input payload_index, input frame_length, output ready
  );
endinterface

// ===== rtl/isp_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// Framed packet deframer
// Splits a byte stream into header/length/payload/checksum/tail frames.
// ----------------------------------------------------------------------------
// Every received byte produces exactly one result transaction, registered in
// the cycle after acceptance. The block hunts for the header 46 B9 68 00, reads a
// length byte (payload count is length minus 6), passes out each payload byte
// with its index, checks the 16-bit sum of 0x68, 0x00, the length and the
// payload (high byte, then low byte) and finally the tail 0x16. Mismatches
// are reported with their own event code and the block returns to hunting.
// Throughput is one byte per clock: the phase update, the sum add and the
// compares sit between the input channel and a single result register, and
// a new byte is taken whenever that register is empty or being drained.
`timescale 1ns / 1ps

`include "isp_frame_deframer_macros.svh"

module isp_frame_deframer
  import ifd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  ifd_in_if.sink    in_ch,
  ifd_out_if.source out_ch
);

  // Frame state.
  phase_t      phase;
  phase_t      phase_next;
  logic [15:0] running_sum;
  logic [15:0] running_sum_next;
  logic [7:0]  payload_count;
  logic [7:0]  payload_count_next;
  logic [7:0]  payload_position;
  logic [7:0]  payload_position_next;

  // Result register.
  logic        out_valid;
  event_t      ev_reg;
  logic [7:0]  pbyte_reg;
  logic [7:0]  pidx_reg;
  logic [7:0]  flen_reg;

  // Result of the current byte.
  event_t      ev_next;
  logic [7:0]  pbyte_next;
  logic [7:0]  pidx_next;
  logic [7:0]  flen_next;

  logic [7:0]  b;
  logic        in_acc;
  logic [7:0]  len_count;
  logic [7:0]  pos_inc;

  assign b         = in_ch.rx_byte;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign len_count = b - LEN_OFFSET;
  assign pos_inc   = payload_position + 8'd1;

  // A new byte is taken while the result register is empty or draining.
  assign in_ch.ready = !out_valid || out_ch.ready;

  // Next phase.
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HUNT:  if (b == HDR_FIRST) phase_next = PH_H1;
      PH_H1:    phase_next = (b == HDR_SECOND) ? PH_H2 : PH_HUNT;
      PH_H2:    phase_next = (b == HDR_THIRD) ? PH_H3 : PH_HUNT;
      PH_H3:    phase_next = (b == HDR_FOURTH) ? PH_LEN : PH_HUNT;
      PH_LEN: begin
        if (b < LEN_OFFSET) begin
          phase_next = PH_HUNT;
        end else if (len_count == 8'd0) begin
          phase_next = PH_SUMHI;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA:  if (pos_inc >= payload_count) phase_next = PH_SUMHI;
      PH_SUMHI: phase_next = (b == running_sum[15:8]) ? PH_SUMLO : PH_HUNT;
      PH_SUMLO: phase_next = (b == running_sum[7:0]) ? PH_TAIL : PH_HUNT;
      PH_TAIL:  phase_next = PH_HUNT;
      default:  phase_next = PH_HUNT;
    endcase
  end

  // Result fields and datapath updates.
  always_comb begin
    ev_next               = EV_NONE;
    pbyte_next            = 8'd0;
    pidx_next             = 8'd0;
    flen_next             = 8'd0;
    running_sum_next      = running_sum;
    payload_count_next    = payload_count;
    payload_position_next = payload_position;
    case (phase)
      PH_HUNT:  ev_next = EV_NONE;
      PH_H1:    if (b != HDR_SECOND) ev_next = EV_HEADER;
      PH_H2:    if (b != HDR_THIRD) ev_next = EV_HEADER;
      PH_H3:    if (b != HDR_FOURTH) ev_next = EV_HEADER;
      PH_LEN: begin
        if (b < LEN_OFFSET) begin
          ev_next = EV_LENGTH;
        end else begin
          running_sum_next      = {8'd0, b} + {8'd0, HDR_THIRD};
          payload_count_next    = len_count;
          payload_position_next = 8'd0;
        end
      end
      PH_DATA: begin
        ev_next               = EV_DATA;
        pbyte_next            = b;
        pidx_next             = payload_position;
        running_sum_next      = running_sum + {8'd0, b};
        payload_position_next = pos_inc;
      end
      PH_SUMHI: if (b != running_sum[15:8]) ev_next = EV_SUMHI;
      PH_SUMLO: if (b != running_sum[7:0]) ev_next = EV_SUMLO;
      PH_TAIL: begin
        if (b == TAIL_BYTE) begin
          ev_next   = EV_GOOD;
          flen_next = payload_count;
        end else begin
          ev_next = EV_TAIL;
        end
      end
      default:  ev_next = EV_NONE;
    endcase
  end

  // State registers advance on each accepted input transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      running_sum      <= 16'd0;
      payload_count    <= 8'd0;
      payload_position <= 8'd0;
    end else if (in_acc) begin
      phase            <= phase_next;
      running_sum      <= running_sum_next;
      payload_count    <= payload_count_next;
      payload_position <= payload_position_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_reg    <= ev_next;
      pbyte_reg <= pbyte_next;
      pidx_reg  <= pidx_next;
      flen_reg  <= flen_next;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.frame_event   = ev_reg;
  assign out_ch.payload_byte  = pbyte_reg;
  assign out_ch.payload_index = pidx_reg;
  assign out_ch.frame_length  = flen_reg;

  // Checks on the frame state and the result register.
  `IFD_ASSERT_SAME(a_pos_in_range, phase == PH_DATA, payload_position < payload_count, "payload position past count")
  `IFD_ASSERT_SAME(a_idx_in_range, out_valid && ev_reg == EV_DATA, pidx_reg < payload_count, "payload index past count")
  `IFD_ASSERT_SAME(a_len_on_good, out_valid && ev_reg == EV_GOOD, flen_reg == payload_count, "frame length differs from count")
  `IFD_ASSERT_SAME(a_len_zero, out_valid && ev_reg != EV_GOOD, flen_reg == 8'd0, "frame length set without good frame")
  `IFD_ASSERT_NEXT(a_hunt_stays, in_acc && phase == PH_HUNT && b != HDR_FIRST, phase == PH_HUNT && out_valid && ev_reg == EV_NONE, "hunt left without header byte")

endmodule

// ===== bench/ifd_frame_checker.sv =====
// ----------------------------------------------------------------------------
// Frame deframer result checker
// Watches both channels of the deframer. It predicts the result of every
// accepted byte and compares the results that come out, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ifd_frame_checker
  import ifd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ifd_in_if    in_mon,
  ifd_out_if   out_mon,
  output int   mismatch_count,
  output int   pending,
  output int   checked_count,
  output int   good_count
);

  localparam int MAX_REPORTS = 10;

  // One predicted result transaction.
  typedef struct packed {
    event_t     ev;
    logic [7:0] data;
    logic [7:0] index;
    logic [7:0] length;
  } frame_result_t;

  // Predictor state, kept apart from the block's own.
  phase_t        rx_phase;
  logic [15:0]   frame_sum;
  logic [7:0]    data_total;
  logic [7:0]    data_seen;
  frame_result_t expected_events[$];

  // Advances the receive state by one byte and returns the event it causes.
  function automatic frame_result_t deframe_byte(input logic [7:0] b);
    frame_result_t r;
    r = '0;
    r.ev = EV_NONE;
    case (rx_phase)
      PH_HUNT: begin
        if (b == HDR_FIRST) rx_phase = PH_H1;
      end
      PH_H1: begin
        if (b == HDR_SECOND) begin
          rx_phase = PH_H2;
        end else begin
          r.ev = EV_HEADER;
          rx_phase = PH_HUNT;
        end
      end
      PH_H2: begin
        if (b == HDR_THIRD) begin
          rx_phase = PH_H3;
        end else begin
          r.ev = EV_HEADER;
          rx_phase = PH_HUNT;
        end
      end
      PH_H3: begin
        if (b == HDR_FOURTH) begin
          rx_phase = PH_LEN;
        end else begin
          r.ev = EV_HEADER;
          rx_phase = PH_HUNT;
        end
      end
      PH_LEN: begin
        if (b < LEN_OFFSET) begin
          r.ev = EV_LENGTH;
          rx_phase = PH_HUNT;
        end else begin
          // The sum starts with the third header byte and the length.
          frame_sum = 16'(HDR_THIRD) + 16'(b);
          data_total = b - LEN_OFFSET;
          data_seen = 8'd0;
          rx_phase = (data_total == 8'd0) ? PH_SUMHI : PH_DATA;
        end
      end
      PH_DATA: begin
        frame_sum = frame_sum + 16'(b);
        r.ev = EV_DATA;
        r.data = b;
        r.index = data_seen;
        data_seen = data_seen + 8'd1;
        if (data_seen >= data_total) rx_phase = PH_SUMHI;
      end
      PH_SUMHI: begin
        if (b == frame_sum[15:8]) begin
          rx_phase = PH_SUMLO;
        end else begin
          r.ev = EV_SUMHI;
          rx_phase = PH_HUNT;
        end
      end
      PH_SUMLO: begin
        if (b == frame_sum[7:0]) begin
          rx_phase = PH_TAIL;
        end else begin
          r.ev = EV_SUMLO;
          rx_phase = PH_HUNT;
        end
      end
      PH_TAIL: begin
        if (b == TAIL_BYTE) begin
          r.ev = EV_GOOD;
          r.length = data_total;
        end else begin
          r.ev = EV_TAIL;
        end
        rx_phase = PH_HUNT;
      end
      default: begin
        rx_phase = PH_HUNT;
      end
    endcase
    return r;
  endfunction

  // Results are checked before the byte of the same edge is predicted, since
  // a result never leaves in the cycle its byte is taken.
  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      rx_phase = PH_HUNT;
      frame_sum = 16'd0;
      data_total = 8'd0;
      data_seen = 8'd0;
      expected_events.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        checked_count++;
        if (expected_events.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result transaction with none expected (event %0d)",
                     $time, out_mon.frame_event);
        end else begin
          want = expected_events.pop_front();
          if (want.ev == EV_GOOD) good_count++;
          if (out_mon.frame_event !== want.ev || out_mon.payload_byte !== want.data ||
              out_mon.payload_index !== want.index ||
              out_mon.frame_length !== want.length) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display({"%0t: expected event %0d byte %02h index %0d length %0d,",
                        " got event %0d byte %02h index %0d length %0d"},
                       $time, want.ev, want.data, want.index, want.length,
                       out_mon.frame_event, out_mon.payload_byte,
                       out_mon.payload_index, out_mon.frame_length);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_events.push_back(deframe_byte(in_mon.rx_byte));
    end
    pending = expected_events.size();
  end

endmodule

// ===== bench/isp_frame_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// Frame deframer testbench
// Feeds directed and random byte streams, mostly well-formed frames with
// injected faults, under random sender gaps and receiver stalls. A checker
// beside the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isp_frame_deframer_tb
  import ifd_pkg::*;
;

  localparam int CLK_HALF     = 6;
  localparam int RST_CYCLES   = 7;
  localparam int RAND_BYTES   = 900;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  // Ways in which a generated frame is spoiled.
  typedef enum logic [2:0] {
    FLT_NONE,
    FLT_HEADER,
    FLT_LENGTH,
    FLT_TRUNC,
    FLT_SUMHI,
    FLT_SUMLO,
    FLT_TAIL
  } fault_t;

  logic clk = 1'b0;
  logic rst;

  ifd_in_if  in_ch ();
  ifd_out_if out_ch ();

  int mismatch_count;
  int pending;
  int checked_count;
  int good_count;

  int burst_left;
  int bytes_sent;
  int frames_built;
  int faulty_frames;
  int idle_cycles;
  logic [9:0] rcv_cyc = 10'd0;

  isp_frame_deframer uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ifd_frame_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .pending        (pending),
    .checked_count  (checked_count),
    .good_count     (good_count)
  );

  // Clock generation.
  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // The receiver cycles through always ready, light, heavy and periodic stalls.
  always @(negedge clk) begin
    rcv_cyc <= rcv_cyc + 10'd1;
    case (rcv_cyc[7:6])
      2'd0: out_ch.ready <= 1'b1;
      2'd1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= (rcv_cyc[2:0] != 3'd7);
    endcase
  end

  // Watchdog: the run ends if no transaction moves on either channel too long.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] flip_mask();
    return 8'($urandom_range(1, 255));
  endfunction

  // Sends one byte in bursts separated by random gaps. Called and returning
  // at a falling edge; valid stays high inside a burst.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // Holds the sender off until every predicted result has come out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Builds and sends one frame of the given length, spoiled as requested.
  // A spoiled frame ends right after the bad byte, a truncated one mid-payload.
  task automatic send_frame(input logic [7:0] len, input fault_t fault);
    logic [7:0]  hdr [4];
    logic [15:0] csum;
    logic [7:0]  b;
    int          bad_pos;
    int          n_data;
    hdr = '{HDR_FIRST, HDR_SECOND, HDR_THIRD, HDR_FOURTH};
    frames_built++;
    if (fault != FLT_NONE) faulty_frames++;
    bad_pos = (fault == FLT_HEADER) ? $urandom_range(1, 3) : 4;
    for (int i = 0; i < 4; i++) begin
      if (i == bad_pos) begin
        send_byte(hdr[i] ^ flip_mask());
        return;
      end
      send_byte(hdr[i]);
    end
    if (fault == FLT_LENGTH) begin
      send_byte(8'($urandom_range(0, 5)));
      return;
    end
    send_byte(len);
    csum = 16'(HDR_THIRD) + 16'(HDR_FOURTH) + 16'(len);
    n_data = int'(len) - int'(LEN_OFFSET);
    if (fault == FLT_TRUNC) n_data = n_data / 2;
    for (int i = 0; i < n_data; i++) begin
      b = 8'($urandom);
      csum = csum + 16'(b);
      send_byte(b);
    end
    if (fault == FLT_TRUNC) return;
    send_byte(fault == FLT_SUMHI ? csum[15:8] ^ flip_mask() : csum[15:8]);
    if (fault == FLT_SUMHI) return;
    send_byte(fault == FLT_SUMLO ? csum[7:0] ^ flip_mask() : csum[7:0]);
    if (fault == FLT_SUMLO) return;
    send_byte(fault == FLT_TAIL ? TAIL_BYTE ^ flip_mask() : TAIL_BYTE);
  endtask

  // Stimulus and verdict.
  initial begin
    fault_t     fault;
    logic [7:0] len;
    int         pick;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'd0;
    burst_left = 0;
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: idle noise at both byte extremes, a frame with no payload,
    // one with a single payload byte, header faults at each position where
    // one can occur, a zero length and bad sum and tail bytes.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'd6, FLT_NONE);
    send_frame(8'd7, FLT_NONE);
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'h00);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(HDR_THIRD);
    send_byte(8'hFF);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(HDR_THIRD);
    send_byte(HDR_FOURTH);
    send_byte(8'h00);
    send_frame(8'd6, FLT_SUMHI);
    send_frame(8'd7, FLT_SUMLO);
    send_frame(8'd8, FLT_TAIL);
    wait_drained();

    // Random: mostly good frames with random payload, the longest first, and
    // the rest spoiled frames and stray bytes between frames.
    send_frame(8'd255, FLT_NONE);
    while (bytes_sent < RAND_BYTES) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
      pick = $urandom_range(0, 99);
      if (pick < 55)      fault = FLT_NONE;
      else if (pick < 63) fault = FLT_HEADER;
      else if (pick < 71) fault = FLT_LENGTH;
      else if (pick < 78) fault = FLT_TRUNC;
      else if (pick < 85) fault = FLT_SUMHI;
      else if (pick < 92) fault = FLT_SUMLO;
      else                fault = FLT_TAIL;
      len = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(6, 255))
                                         : 8'($urandom_range(6, 22));
      send_frame(len, fault);
      if (frames_built % 40 == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d bytes in %0d frames, %0d of them spoiled on purpose.",
             bytes_sent, frames_built, faulty_frames);
    $display("Checked %0d result transactions, %0d of them good frames.",
             checked_count, good_count);
    if (mismatch_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== isp_frame_deframer.f =====
+incdir+rtl
rtl/ifd_pkg.sv
rtl/ifd_in_if.sv
rtl/ifd_out_if.sv
rtl/isp_frame_deframer.sv
bench/ifd_frame_checker.sv
bench/isp_frame_deframer_tb.sv
